// ===== hdl/ssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the servo status packet parser
// The package holds the command codes that pass from the front end to the back
// end, the queue entry layout and the default queue depth.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam logic [7:0] HeaderByte   = 8'hFF;
  localparam logic [7:0] MinLength    = 8'd2;
  localparam int         QueueDepthDef = 2;

  // Commands that the front end hands to the back end, one for each byte that
  // carries meaning. Header bytes and bytes between packets give no command.
  typedef enum logic [2:0] {
    OP_ID      = 3'd0,
    OP_LEN_OK  = 3'd1,
    OP_LEN_BAD = 3'd2,
    OP_ERR     = 3'd3,
    OP_PARAM   = 3'd4,
    OP_CSUM    = 3'd5
  } ssp_op_e;

  typedef struct packed {
    ssp_op_e    op;
    logic [7:0] data;
  } ssp_cmd_t;

  // Push side of the command queue, as seen from the front end.
  typedef struct packed {
    logic     push;
    ssp_cmd_t cmd;
  } ssp_push_t;

endpackage

// ===== hdl/ssp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_in_if: received byte channel
// Valid/ready channel that carries one received byte per item.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/ssp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_out_if: parsed item channel
// Valid/ready channel that carries parameter bytes and packet summaries.
// ----------------------------------------------------------------------------
interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] node_id;
  logic [7:0] error_flags;
  logic [7:0] data_byte;
  logic [7:0] param_index;
  logic       checksum_ok;
  logic       bad_length;
  logic       last;

  modport source (output valid, output kind, output node_id, output error_flags,
                  output data_byte, output param_index, output checksum_ok,
                  output bad_length, output last, input ready);
  modport sink   (input valid, input kind, input node_id, input error_flags,
                  input data_byte, input param_index, input checksum_ok,
                  input bad_length, input last, output ready);
endinterface

// ===== hdl/servo_status_packet_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_packet_parser: servo bus status packet parser
// Parses received bytes into parameter items and one summary per packet.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   rx_i     in   valid/ready   rx_byte
//   res_o    out  valid/ready   kind, node_id, error_flags, data_byte,
//                               param_index, checksum_ok, bad_length, last
//
// One byte per cycle sustained on rx_i while res_o is not stalled. A taken
// byte is classified by the framing state machine, queued, then executed
// into the output register. Reset clears the framing phase, the queue and
// the packet state; no clearing pass is needed. A stalled output fills the
// command queue, after which rx_i.ready drops until the output register
// drains.
//
module servo_status_packet_parser
  import ssp_pkg::*;
#(
  parameter int QDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssp_in_if.sink    rx_i,
  ssp_out_if.source res_o
);

  ssp_push_t push;
  logic      q_full;
  logic      q_empty;
  logic      pop;
  ssp_cmd_t  cmd;

  // Front end: hunt for the header, track length and parameter count.
  ssp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  // Command queue: lets the front keep taking bytes while a result waits.
  ssp_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (cmd)
  );

  // Back end: running checksum, packet fields and the output register.
  ssp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .cmd_i   (cmd),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// ===== hdl/ssp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_front: framing front end
// Hunts for the header, tracks the packet phase and the parameter count, and
// turns each meaningful byte into a command for the back end.
// ----------------------------------------------------------------------------
module ssp_front
  import ssp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ssp_in_if.sink     rx_i,
  input  logic       q_full_i,
  output ssp_push_t  push_o
);

  typedef enum logic [6:0] {
    PH_HDR1  = 7'b0000001,
    PH_HDR2  = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_ERR   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } ssp_phase_e;

  ssp_phase_e phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic       fire;
  logic [7:0] b;

  assign rx_i.ready = !q_full_i;
  assign fire       = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  always_comb begin
    phase_d         = phase_q;
    len_d           = len_q;
    cnt_d           = cnt_q;
    push_o.push     = 1'b0;
    push_o.cmd.op   = OP_ID;
    push_o.cmd.data = b;
    if (fire) begin
      unique case (phase_q)
        PH_HDR1: begin
          if (b == HeaderByte) phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          phase_d = (b == HeaderByte) ? PH_ID : PH_HDR1;
        end
        PH_ID: begin
          push_o.push = 1'b1;
          phase_d     = PH_LEN;
        end
        PH_LEN: begin
          push_o.push = 1'b1;
          len_d       = b;
          if (b < MinLength) begin
            push_o.cmd.op = OP_LEN_BAD;
            phase_d       = PH_HDR1;
          end else begin
            push_o.cmd.op = OP_LEN_OK;
            phase_d       = PH_ERR;
          end
        end
        PH_ERR: begin
          push_o.push   = 1'b1;
          push_o.cmd.op = OP_ERR;
          cnt_d         = '0;
          phase_d       = (len_q == MinLength) ? PH_CSUM : PH_PARAM;
        end
        PH_PARAM: begin
          push_o.push   = 1'b1;
          push_o.cmd.op = OP_PARAM;
          cnt_d         = cnt_q + 8'd1;
          // leave after the byte that brings the count up to length - 2
          if (({1'b0, cnt_q} + 9'd3) >= {1'b0, len_q}) phase_d = PH_CSUM;
        end
        PH_CSUM: begin
          push_o.push   = 1'b1;
          push_o.cmd.op = OP_CSUM;
          phase_d       = PH_HDR1;
        end
        default: phase_d = PH_HDR1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR1;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> !q_full_i)
    else $error("front pushed into a full queue");

  a_param_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PARAM) |-> (({1'b0, cnt_q} + 9'd2) < {1'b0, len_q}))
    else $error("parameter count ran past the packet length");

  a_len_ok_after_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PARAM || phase_q == PH_CSUM || phase_q == PH_ERR)
      |-> (len_q >= MinLength))
    else $error("packet body entered with a short length");

endmodule

// ===== hdl/ssp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_queue: command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ssp_queue
  import ssp_pkg::*;
#(
  parameter int QDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ssp_push_t push_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output ssp_cmd_t  cmd_o
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  ssp_cmd_t        mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("queue count above depth");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

// ===== hdl/ssp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_back: packet back end
// Executes the commands: keeps id, error byte, running checksum and parameter
// index, and fills the output register with parameter and summary items.
// ----------------------------------------------------------------------------
module ssp_back
  import ssp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  ssp_cmd_t  cmd_i,
  output logic      pop_o,
  ssp_out_if.source res_o
);

  logic [7:0] id_q, id_d;
  logic [7:0] err_q, err_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] idx_q, idx_d;

  logic       out_valid_q, out_valid_d;
  logic       kind_q, kind_d;
  logic [7:0] oid_q, oid_d;
  logic [7:0] oerr_q, oerr_d;
  logic [7:0] odata_q, odata_d;
  logic [7:0] oidx_q, oidx_d;
  logic       ok_q, ok_d;
  logic       bad_q, bad_d;
  logic       last_q, last_d;
  logic       emit;

  // Take a command whenever the output register is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || res_o.ready);

  always_comb begin
    id_d    = id_q;
    err_d   = err_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    emit    = 1'b0;
    kind_d  = kind_q;
    oid_d   = oid_q;
    oerr_d  = oerr_q;
    odata_d = odata_q;
    oidx_d  = oidx_q;
    ok_d    = ok_q;
    bad_d   = bad_q;
    last_d  = last_q;
    if (pop_o) begin
      unique case (cmd_i.op)
        OP_ID: begin
          id_d  = cmd_i.data;
          sum_d = cmd_i.data;
        end
        OP_LEN_OK: begin
          sum_d = sum_q + cmd_i.data;
        end
        OP_LEN_BAD: begin
          emit    = 1'b1;
          kind_d  = 1'b1;
          oid_d   = id_q;
          oerr_d  = '0;
          odata_d = '0;
          oidx_d  = '0;
          ok_d    = 1'b0;
          bad_d   = 1'b1;
          last_d  = 1'b1;
        end
        OP_ERR: begin
          err_d = cmd_i.data;
          sum_d = sum_q + cmd_i.data;
          idx_d = '0;
        end
        OP_PARAM: begin
          emit    = 1'b1;
          kind_d  = 1'b0;
          oid_d   = id_q;
          oerr_d  = err_q;
          odata_d = cmd_i.data;
          oidx_d  = idx_q;
          ok_d    = 1'b0;
          bad_d   = 1'b0;
          last_d  = 1'b0;
          sum_d   = sum_q + cmd_i.data;
          idx_d   = idx_q + 8'd1;
        end
        OP_CSUM: begin
          emit    = 1'b1;
          kind_d  = 1'b1;
          oid_d   = id_q;
          oerr_d  = err_q;
          odata_d = '0;
          oidx_d  = '0;
          ok_d    = (~sum_q == cmd_i.data);
          bad_d   = 1'b0;
          last_d  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (emit)             out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      err_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      id_q        <= id_d;
      err_q       <= err_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    oid_q   <= oid_d;
    oerr_q  <= oerr_d;
    odata_q <= odata_d;
    oidx_q  <= oidx_d;
    ok_q    <= ok_d;
    bad_q   <= bad_d;
    last_q  <= last_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = kind_q;
  assign res_o.node_id     = oid_q;
  assign res_o.error_flags = oerr_q;
  assign res_o.data_byte   = odata_q;
  assign res_o.param_index = oidx_q;
  assign res_o.checksum_ok = ok_q;
  assign res_o.bad_length  = bad_q;
  assign res_o.last        = last_q;

  a_summary_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q == last_q))
    else $error("summary and last marker disagree");

  a_param_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !kind_q) |-> (!ok_q && !bad_q))
    else $error("parameter item carries summary flags");

  a_bad_len_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bad_q) |-> (kind_q && !ok_q && oerr_q == '0))
    else $error("short length summary malformed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !pop_o)
    else $error("command taken while a result is stalled");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for servo_status_packet_parser
// Feeds received bytes through the rx channel and checks every parameter item
// and packet summary against an in-bench parser that tracks the framing state,
// the running checksum and the parameter count, with random stalls both ways.
// ----------------------------------------------------------------------------
module testbench;
  import ssp_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 20;
  localparam int RandomBytes  = 500;
  localparam int QuietTail    = 80;

  // Framing phases of the in-bench parser.
  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_ID,
    TAKE_LEN,
    TAKE_ERR,
    TAKE_PARAM,
    TAKE_CSUM
  } frame_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] node_id;
    logic [7:0] error_flags;
    logic [7:0] data_byte;
    logic [7:0] param_index;
    logic       checksum_ok;
    logic       bad_length;
    logic       last;
  } parsed_item_t;

  // One received byte waiting to be sent; hold_for_drain makes the sender
  // wait until every outstanding parsed item has come back first.
  typedef struct packed {
    logic [7:0] value;
    logic       hold_for_drain;
  } rx_entry_t;

  logic clk;
  logic rst_n;

  ssp_in_if  rx_if ();
  ssp_out_if res_if ();

  servo_status_packet_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  rx_entry_t    rx_bytes_q[$];
  parsed_item_t parsed_items_q[$];

  // Parser state mirrored in the bench.
  frame_phase_e phase;
  logic [7:0]   pkt_id;
  logic [7:0]   pkt_len;
  logic [7:0]   pkt_err;
  logic [7:0]   sum_acc;
  logic [7:0]   param_count;

  logic rx_took;
  logic drain_next;
  int   send_gap;
  int   stall_left;
  int   error_count;
  int   cycle_count;
  int   bytes_taken;
  int   summaries_seen;
  int   params_seen;
  int   short_len_seen;
  int   bad_sum_seen;

  // The last stretch of the run goes without idling on either side.
  function automatic bit quiet();
    return (rx_bytes_q.size() < QuietTail);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] value);
    rx_entry_t e;
    e.value          = value;
    e.hold_for_drain = drain_next;
    drain_next       = 1'b0;
    rx_bytes_q.push_back(e);
  endtask

  // Build a whole status packet. With extremes set, the parameters cycle
  // through 00, FF, 80, 7F, 01; otherwise they are random. With corrupt set,
  // the checksum byte is flipped in at least one bit.
  task automatic add_packet(input logic [7:0] id, input logic [7:0] len,
                            input logic [7:0] err, input bit corrupt,
                            input bit extremes);
    logic [7:0] sum;
    logic [7:0] p;
    logic [7:0] pattern[5];
    pattern = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    add_byte(HeaderByte);
    add_byte(HeaderByte);
    add_byte(id);
    add_byte(len);
    if (len < MinLength) begin
      return;
    end
    add_byte(err);
    sum = id + len + err;
    for (int i = 0; i < int'(len) - 2; i++) begin
      p = extremes ? pattern[i % 5] : 8'($urandom_range(0, 255));
      add_byte(p);
      sum += p;
    end
    sum = ~sum;
    if (corrupt) begin
      sum ^= 8'($urandom_range(1, 255));
    end
    add_byte(sum);
  endtask

  // --------------------------------------------------------------------------
  // Prediction: advance the mirrored parser by one accepted byte and queue
  // the item it produces, if any.
  // --------------------------------------------------------------------------
  task automatic predict_byte(input logic [7:0] b);
    parsed_item_t item;
    bit           produces;
    logic [7:0]   want_sum;
    item     = '0;
    produces = 1'b0;
    case (phase)
      HUNT_FIRST: begin
        // Drop anything but a header byte between packets.
        if (b == HeaderByte) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        // A broken header sends the parser back to hunting.
        phase = (b == HeaderByte) ? TAKE_ID : HUNT_FIRST;
      end
      TAKE_ID: begin
        pkt_id  = b;
        sum_acc = b;
        phase   = TAKE_LEN;
      end
      TAKE_LEN: begin
        pkt_len = b;
        if (b < MinLength) begin
          // Short length: abort with a summary; no error byte seen yet.
          item.kind       = 1'b1;
          item.node_id    = pkt_id;
          item.bad_length = 1'b1;
          item.last       = 1'b1;
          produces        = 1'b1;
          phase           = HUNT_FIRST;
        end else begin
          sum_acc += b;
          phase    = TAKE_ERR;
        end
      end
      TAKE_ERR: begin
        pkt_err     = b;
        sum_acc    += b;
        param_count = '0;
        // A length of two carries no parameters at all.
        phase = (pkt_len == MinLength) ? TAKE_CSUM : TAKE_PARAM;
      end
      TAKE_PARAM: begin
        item.node_id     = pkt_id;
        item.error_flags = pkt_err;
        item.data_byte   = b;
        item.param_index = param_count;
        produces         = 1'b1;
        sum_acc         += b;
        param_count     += 1'b1;
        if (int'(param_count) + 2 >= int'(pkt_len)) phase = TAKE_CSUM;
      end
      TAKE_CSUM: begin
        want_sum         = ~sum_acc;
        item.kind        = 1'b1;
        item.node_id     = pkt_id;
        item.error_flags = pkt_err;
        item.checksum_ok = (want_sum == b);
        item.last        = 1'b1;
        produces         = 1'b1;
        phase            = HUNT_FIRST;
      end
      default: phase = HUNT_FIRST;
    endcase
    if (produces) parsed_items_q.push_back(item);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
      error_count++;
    end
  endtask

  task automatic check_result();
    parsed_item_t got;
    parsed_item_t want;
    got.kind        = res_if.kind;
    got.node_id     = res_if.node_id;
    got.error_flags = res_if.error_flags;
    got.data_byte   = res_if.data_byte;
    got.param_index = res_if.param_index;
    got.checksum_ok = res_if.checksum_ok;
    got.bad_length  = res_if.bad_length;
    got.last        = res_if.last;
    if (parsed_items_q.size() == 0) begin
      $display("%0t: unexpected item, expected none, actual %h", $time, got);
      error_count++;
    end else begin
      want = parsed_items_q.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("node_id", want.node_id, got.node_id);
      compare_field("error_flags", want.error_flags, got.error_flags);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("param_index", want.param_index, got.param_index);
      compare_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
      compare_field("bad_length", 8'(want.bad_length), 8'(got.bad_length));
      compare_field("last", 8'(want.last), 8'(got.last));
      if (want.kind) begin
        summaries_seen++;
        if (want.bad_length) short_len_seen++;
        else if (!want.checksum_ok) bad_sum_seen++;
      end else begin
        params_seen++;
      end
    end
  endtask

  // Monitor: sample both channels at the rising edge. Check first, so that
  // an item appearing before its byte was even taken is caught as stray.
  always @(posedge clk) begin
    rx_took = rst_n && rx_if.valid && rx_if.ready;
    if (rst_n && res_if.valid && res_if.ready) check_result();
    if (rx_took) begin
      bytes_taken++;
      predict_byte(rx_if.rx_byte);
    end
  end

  // --------------------------------------------------------------------------
  // Driver: present the next byte at the falling edge once the current one
  // has been taken. Hold a byte flagged for drain until nothing is pending.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_rx
    logic       next_valid;
    logic [7:0] next_value;
    rx_entry_t  e;
    if (rst_n && (!rx_if.valid || rx_took)) begin
      next_valid = 1'b0;
      next_value = rx_if.rx_byte;
      if (send_gap > 0) begin
        send_gap--;
      end else if (rx_bytes_q.size() != 0 &&
                   !(rx_bytes_q[0].hold_for_drain && parsed_items_q.size() != 0)) begin
        e          = rx_bytes_q.pop_front();
        next_valid = 1'b1;
        next_value = e.value;
        // Start an idle burst after this byte now and then.
        if (!quiet() && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
      end
      rx_if.valid   <= next_valid;
      rx_if.rx_byte <= next_value;
    end
  end

  // Receiver: stall in random bursts, none in the quiet tail.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!quiet() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if it takes far longer than any correct run could.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out after %0d cycles", $time, cycle_count);
    $display("testbench: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int sel;
    int random_added;
    int mark;
    int pkt_n;
    int cut;
    logic [7:0] len;

    rst_n          = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    rx_took        = 1'b0;
    drain_next     = 1'b0;
    send_gap       = 0;
    stall_left     = 0;
    error_count    = 0;
    bytes_taken    = 0;
    summaries_seen = 0;
    params_seen    = 0;
    short_len_seen = 0;
    bad_sum_seen   = 0;
    phase          = HUNT_FIRST;
    pkt_id         = '0;
    pkt_len        = '0;
    pkt_err        = '0;
    sum_acc        = '0;
    param_count    = '0;

    // Directed part: a dropped stray byte, a broken header, both short
    // lengths (one with id FF), a parameterless packet with a bad checksum,
    // and a packet of extreme parameter values with a good checksum.
    add_byte(8'h00);
    add_byte(HeaderByte);
    add_byte(8'h3C);
    add_packet(8'h07, 8'd0, 8'h00, 1'b0, 1'b0);
    add_packet(8'hFF, 8'd1, 8'h00, 1'b0, 1'b0);
    add_packet(8'h01, 8'd2, 8'h00, 1'b1, 1'b0);
    add_packet(8'h00, 8'd5, 8'hFF, 1'b0, 1'b1);

    // Random part: mostly well-formed packets with random content, some
    // short lengths, noise, broken headers and cut-off packets. Hold the
    // first byte of this part and one more later until all items are back.
    drain_next   = 1'b1;
    random_added = 0;
    pkt_n        = 0;
    while (random_added < RandomBytes) begin
      mark = rx_bytes_q.size();
      sel  = $urandom_range(0, 19);
      if (pkt_n == 25) drain_next = 1'b1;
      if (pkt_n == 15) begin
        // One packet of the largest length reaches the top parameter index.
        add_packet(8'($urandom_range(0, 255)), 8'd255, 8'($urandom_range(0, 255)),
                   1'b0, 1'b0);
        mark = rx_bytes_q.size();
      end else if (sel <= 13) begin
        add_packet(8'($urandom_range(0, 255)), 8'($urandom_range(2, 12)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0, 1'b0);
      end else if (sel <= 15) begin
        add_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)), 8'h00,
                   1'b0, 1'b0);
      end else if (sel <= 17) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 254)));
      end else if (sel == 18) begin
        add_byte(HeaderByte);
        add_byte(8'($urandom_range(0, 254)));
      end else begin
        // Cut a packet short; whatever follows is parsed as its remainder.
        len = 8'($urandom_range(3, 10));
        add_byte(HeaderByte);
        add_byte(HeaderByte);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(len);
        cut = $urandom_range(0, int'(len) - 2);
        repeat (cut) add_byte(8'($urandom_range(0, 255)));
      end
      random_added += rx_bytes_q.size() - mark;
      pkt_n++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every byte to be taken, then for every item to come back,
    // then a little longer to catch any stray item.
    while (rx_bytes_q.size() != 0 || rx_if.valid) @(posedge clk);
    while (parsed_items_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes; checked %0d parameter items and %0d packet summaries,",
             bytes_taken, params_seen, summaries_seen);
    $display("of which %0d were short-length aborts and %0d had a checksum mismatch.",
             short_len_seen, bad_sum_seen);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ssp_pkg.sv
hdl/ssp_in_if.sv
hdl/ssp_out_if.sv
hdl/ssp_front.sv
hdl/ssp_queue.sv
hdl/ssp_back.sv
hdl/servo_status_packet_parser.sv
bench/testbench.sv
